>>> hdl/kvt_pkg.sv
package kvt_pkg;

  // Table geometry.
  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned KEY_WIDTH   = 64;
  localparam int unsigned DATA_WIDTH  = 64;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  // Operation codes carried in the request mode field.
  localparam logic [2:0] MODE_PUT      = 3'd0;
  localparam logic [2:0] MODE_PUT_TTL  = 3'd1;
  localparam logic [2:0] MODE_GET      = 3'd2;
  localparam logic [2:0] MODE_REMOVE   = 3'd3;
  localparam logic [2:0] MODE_CONTAINS = 3'd4;
  localparam logic [2:0] MODE_TICK     = 3'd5;

  // Response status codes.
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_MISS = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] key;
    logic [63:0] data_in;
    logic [30:0] ttl_seconds;
  } kvt_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] data_out;
    logic [4:0]  live_count;
  } kvt_rsp_t;

endpackage

>>> hdl/kv_table_with_expiry_unit.sv
// Channel  | Direction | Signals                           | Payload
// ---------+-----------+-----------------------------------+------------------------
// request  | in        | in_valid_i / in_ready_o           | in_req_i  (kvt_req_t)
// response | out       | out_valid_o / out_ready_i         | out_rsp_o (kvt_rsp_t)
//
// A request is captured, then a single key/deadline comparator walks the table
// entry by entry, and then the operation is applied.
// Reset (rst_ni low, asynchronous) clears all valid bits, the time counter and
// the sequencer; the table contents need no clearing.
// A response waits in the output register; the next request may be accepted
// meanwhile, and its apply step holds until the output register is free.
module kv_table_with_expiry_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  kvt_pkg::kvt_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output kvt_pkg::kvt_rsp_t out_rsp_o
);

  localparam int unsigned IdxW = kvt_pkg::IDX_W;
  localparam int unsigned CntW = kvt_pkg::CNT_W;
  localparam int unsigned KeyW = kvt_pkg::KEY_WIDTH;
  localparam int unsigned DatW = kvt_pkg::DATA_WIDTH;
  localparam int unsigned Depth = kvt_pkg::TABLE_DEPTH;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  // Entry storage. Valid bits reset; the rest is only read behind a valid bit.
  logic [KeyW-1:0] entry_key_q      [Depth];
  logic [DatW-1:0] entry_data_q     [Depth];
  logic [63:0]     entry_deadline_q [Depth];
  logic            entry_expires_q  [Depth];
  logic [Depth-1:0] entry_valid_q;

  logic [63:0] now_q;
  logic [1:0]  state_q, state_d;
  logic [IdxW-1:0] idx_q;

  // Captured request and scan results.
  kvt_pkg::kvt_req_t req_q;
  logic            hit_q;
  logic [IdxW-1:0] hit_idx_q;
  logic [DatW-1:0] hit_data_q;
  logic            free_q;
  logic [IdxW-1:0] free_idx_q;
  logic [CntW-1:0] live_q;

  kvt_pkg::kvt_rsp_t out_q;
  logic              out_valid_q;

  // Per-entry scan datapath: one expiry compare and one key compare per cycle.
  logic scan_expired, scan_live, scan_match, scan_last;

  assign scan_expired = entry_valid_q[idx_q] && entry_expires_q[idx_q]
                        && (entry_deadline_q[idx_q] <= now_q);
  assign scan_live    = entry_valid_q[idx_q] && !scan_expired;
  assign scan_match   = scan_live && (entry_key_q[idx_q] == req_q.key[KeyW-1:0]);
  assign scan_last    = (idx_q == IdxW'(Depth - 1));

  // Apply step.
  logic            is_put, is_tick, can_issue, do_write, put_new, do_remove;
  logic [IdxW-1:0] slot;
  logic [64:0]     dl_sum;
  logic [63:0]     deadline;
  logic [CntW-1:0] live_next;
  kvt_pkg::kvt_rsp_t rsp;

  assign is_put    = (req_q.mode == kvt_pkg::MODE_PUT) || (req_q.mode == kvt_pkg::MODE_PUT_TTL);
  assign is_tick   = (req_q.mode == kvt_pkg::MODE_TICK);
  assign can_issue = !out_valid_q || out_ready_i;
  assign do_write  = is_put && (hit_q || free_q);
  assign put_new   = is_put && !hit_q && free_q;
  assign do_remove = (req_q.mode == kvt_pkg::MODE_REMOVE) && hit_q;
  assign slot      = hit_q ? hit_idx_q : free_idx_q;
  assign dl_sum    = {1'b0, now_q} + 65'(req_q.ttl_seconds);
  assign deadline  = dl_sum[64] ? '1 : dl_sum[63:0];

  always_comb begin
    live_next = live_q;
    if (put_new) begin
      live_next = live_q + CntW'(1);
    end else if (do_remove) begin
      live_next = live_q - CntW'(1);
    end
    rsp.status     = kvt_pkg::STATUS_OK;
    rsp.data_out   = '0;
    rsp.live_count = 5'(live_next);
    unique case (req_q.mode)
      kvt_pkg::MODE_PUT, kvt_pkg::MODE_PUT_TTL: begin
        if (!do_write) rsp.status = kvt_pkg::STATUS_FULL;
      end
      kvt_pkg::MODE_GET: begin
        if (hit_q) rsp.data_out = 64'(hit_data_q);
        else rsp.status = kvt_pkg::STATUS_MISS;
      end
      kvt_pkg::MODE_REMOVE, kvt_pkg::MODE_CONTAINS: begin
        if (!hit_q) rsp.status = kvt_pkg::STATUS_MISS;
      end
      default: begin
      end
    endcase
  end

  // Sequencer: idle -> scan every entry -> apply and post the response.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_SCAN;
      ST_SCAN: if (scan_last) state_d = ST_EXEC;
      ST_EXEC: if (can_issue) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      idx_q         <= '0;
      entry_valid_q <= '0;
      now_q         <= '0;
      out_valid_q   <= 1'b0;
      hit_q         <= 1'b0;
      free_q        <= 1'b0;
      live_q        <= '0;
    end else begin
      state_q <= state_d;
      // Post a new response, else drop the one just taken.
      if ((state_q == ST_EXEC) && can_issue) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          idx_q  <= '0;
          hit_q  <= 1'b0;
          free_q <= 1'b0;
          live_q <= '0;
        end
        ST_SCAN: begin
          // Drop expired entries as the scan passes them.
          if (scan_expired) entry_valid_q[idx_q] <= 1'b0;
          if (scan_live) live_q <= live_q + CntW'(1);
          if (scan_match && !hit_q) hit_q <= 1'b1;
          if (!scan_live && !free_q) free_q <= 1'b1;
          if (!scan_last) idx_q <= idx_q + IdxW'(1);
        end
        ST_EXEC: begin
          if (can_issue) begin
            if (do_write) entry_valid_q[slot] <= 1'b1;
            if (do_remove) entry_valid_q[hit_idx_q] <= 1'b0;
            if (is_tick && (now_q != '1)) now_q <= now_q + 64'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload: request capture, scan captures, table contents, response.
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && in_valid_i) req_q <= in_req_i;
    if (state_q == ST_SCAN) begin
      if (scan_match && !hit_q) begin
        hit_idx_q  <= idx_q;
        hit_data_q <= entry_data_q[idx_q];
      end
      if (!scan_live && !free_q) free_idx_q <= idx_q;
    end
    if ((state_q == ST_EXEC) && can_issue) begin
      out_q <= rsp;
      if (do_write) begin
        entry_key_q[slot]  <= req_q.key[KeyW-1:0];
        entry_data_q[slot] <= req_q.data_in[DatW-1:0];
        if (req_q.mode == kvt_pkg::MODE_PUT_TTL) begin
          entry_expires_q[slot]  <= 1'b1;
          entry_deadline_q[slot] <= deadline;
        end else begin
          entry_expires_q[slot]  <= 1'b0;
          entry_deadline_q[slot] <= '0;
        end
      end
    end
  end

endmodule

>>> tb/sv/kv_table_with_expiry_unit_test.sv
module kv_table_with_expiry_unit_test;

  // Modes 6 and 7 carry no operation. Only the expiry sweep runs for them.
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;

  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned KEY_POOL_N   = 20;  // more keys than slots, so the table fills
  localparam int unsigned DRAIN_CYCLES = 40;  // longer than the table scan of one request
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned MAX_REPORTS  = 10;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  kvt_pkg::kvt_req_t in_req_i    = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  kvt_pkg::kvt_rsp_t out_rsp_o;

  kv_table_with_expiry_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 0;
  end

  // Shadow copy of the table. Entry fields count only while tbl_live is set.
  logic [63:0] tbl_key      [kvt_pkg::TABLE_DEPTH];
  logic [63:0] tbl_data     [kvt_pkg::TABLE_DEPTH];
  logic [63:0] tbl_deadline [kvt_pkg::TABLE_DEPTH];
  logic        tbl_expires  [kvt_pkg::TABLE_DEPTH];
  logic        tbl_live     [kvt_pkg::TABLE_DEPTH];
  logic [63:0] tbl_now;

  kvt_pkg::kvt_req_t pending_req_q[$];   // requests still to be offered
  kvt_pkg::kvt_rsp_t rsp_expected_q[$];  // responses owed by the block, oldest first
  logic [63:0]       key_pool [KEY_POOL_N];

  int unsigned item_total   = 0;
  int unsigned req_accepted = 0;
  int unsigned mismatch_cnt = 0;
  logic        rsp_hold     = 1'b0;

  // Apply one request to the shadow table and return the response that it yields.
  function automatic kvt_pkg::kvt_rsp_t kv_table_step(kvt_pkg::kvt_req_t req);
    kvt_pkg::kvt_rsp_t rsp;
    int                slot;
    int unsigned       live;
    logic [64:0]       sum;

    rsp  = '0;
    slot = -1;
    live = 0;

    // Drop every entry whose deadline has come, using the time before any tick.
    for (int i = 0; i < kvt_pkg::TABLE_DEPTH; i++) begin
      if (tbl_live[i] && tbl_expires[i] && tbl_deadline[i] <= tbl_now) tbl_live[i] = 1'b0;
    end

    // Locate the key among live entries. Every operation but tick uses it.
    for (int i = kvt_pkg::TABLE_DEPTH - 1; i >= 0; i--) begin
      if (tbl_live[i] && tbl_key[i] == req.key) slot = i;
    end

    case (req.mode)
      kvt_pkg::MODE_PUT, kvt_pkg::MODE_PUT_TTL: begin
        // Take the lowest free slot for a new key.
        if (slot < 0) begin
          for (int i = kvt_pkg::TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!tbl_live[i]) slot = i;
          end
        end
        if (slot < 0) begin
          rsp.status = kvt_pkg::STATUS_FULL;
        end else begin
          tbl_key[slot]  = req.key;
          tbl_data[slot] = req.data_in;
          tbl_live[slot] = 1'b1;
          if (req.mode == kvt_pkg::MODE_PUT_TTL) begin
            // Saturate the deadline at the top of the 64-bit range.
            sum                = {1'b0, tbl_now} + {34'b0, req.ttl_seconds};
            tbl_expires[slot]  = 1'b1;
            tbl_deadline[slot] = sum[64] ? '1 : sum[63:0];
          end else begin
            tbl_expires[slot]  = 1'b0;
            tbl_deadline[slot] = '0;
          end
        end
      end
      kvt_pkg::MODE_GET: begin
        if (slot < 0) rsp.status = kvt_pkg::STATUS_MISS;
        else rsp.data_out = tbl_data[slot];
      end
      kvt_pkg::MODE_REMOVE: begin
        if (slot < 0) rsp.status = kvt_pkg::STATUS_MISS;
        else tbl_live[slot] = 1'b0;
      end
      kvt_pkg::MODE_CONTAINS: begin
        if (slot < 0) rsp.status = kvt_pkg::STATUS_MISS;
      end
      kvt_pkg::MODE_TICK: begin
        if (tbl_now != '1) tbl_now = tbl_now + 64'd1;
      end
      default: ;
    endcase

    for (int i = 0; i < kvt_pkg::TABLE_DEPTH; i++) begin
      if (tbl_live[i]) live++;
    end
    rsp.live_count = live[4:0];
    return rsp;
  endfunction

  function automatic kvt_pkg::kvt_req_t make_req(logic [2:0] mode, logic [63:0] key,
                                                 logic [63:0] data, logic [30:0] ttl);
    kvt_pkg::kvt_req_t req;
    req.mode        = mode;
    req.key         = key;
    req.data_in     = data;
    req.ttl_seconds = ttl;
    return req;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Split the run into thirds: sender idles less first, then the receiver, then neither.
  function automatic int unsigned sender_idle_pct();
    if (req_accepted < item_total / 3) return 25;
    if (req_accepted < 2 * item_total / 3) return 64;
    return 0;
  endfunction

  function automatic int unsigned receiver_idle_pct();
    if (req_accepted < item_total / 3) return 64;
    if (req_accepted < 2 * item_total / 3) return 25;
    return 0;
  endfunction

  initial begin
    for (int i = 0; i < kvt_pkg::TABLE_DEPTH; i++) tbl_live[i] = 1'b0;
    tbl_now = '0;
  end

  // Request driver: predict each accepted request, then offer the next one or idle.
  // Valid is changed only when the channel is empty or its request was just taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i   <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        rsp_expected_q.push_back(kv_table_step(in_req_i));
        req_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_req_q.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
          in_valid_i <= 1'b1;
          in_req_i   <= pending_req_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Response monitor: check each accepted response against the oldest one owed.
  always @(posedge clk_i or negedge rst_ni) begin
    kvt_pkg::kvt_rsp_t exp_rsp;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (rsp_expected_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("unexpected response: status=%0d data_out=%h live_count=%0d",
                     out_rsp_o.status, out_rsp_o.data_out, out_rsp_o.live_count);
        end else begin
          exp_rsp = rsp_expected_q.pop_front();
          if (out_rsp_o.status !== exp_rsp.status ||
              out_rsp_o.data_out !== exp_rsp.data_out ||
              out_rsp_o.live_count !== exp_rsp.live_count) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
              $display("response mismatch: status %0d/%0d data_out %h/%h live_count %0d/%0d",
                       exp_rsp.status, out_rsp_o.status, exp_rsp.data_out,
                       out_rsp_o.data_out, exp_rsp.live_count, out_rsp_o.live_count);
          end
        end
      end
      out_ready_i <= !rsp_hold && ($urandom_range(99) >= receiver_idle_pct());
    end
  end

  // Hold off the receiver for long stretches while the sender keeps offering, so
  // the output register fills and the block stalls its input.
  initial begin
    wait (item_total != 0);
    for (int n = 1; n <= 2; n++) begin
      while (req_accepted < n * item_total / 4) @(posedge clk_i);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      rsp_hold <= 1'b0;
    end
  end

  initial begin
    #5_000_000;
    $display("kv_table_with_expiry_unit_test: FAIL");
    $finish;
  end

  initial begin
    logic [63:0] key_a;
    logic [63:0] key_b;
    logic [63:0] key_c;
    logic [63:0] key_sel;
    logic [63:0] data;
    logic [30:0] ttl;
    logic [2:0]  mode_sel;
    int unsigned pick;

    key_a = rand64();
    key_b = rand64();
    key_c = rand64();

    // Directed part: empty table, key and data extremes, every operation,
    // zero and maximum TTL, expiry exactly at the deadline, replacing an entry
    // with and without expiry, and the two spare modes.
    pending_req_q.push_back(make_req(kvt_pkg::MODE_GET,      64'd0, 64'd0, 31'd0));
    pending_req_q.push_back(make_req(kvt_pkg::MODE_PUT,      64'd0, '1,    31'd0));
    pending_req_q.push_back(make_req(kvt_pkg::MODE_PUT,      '1,    64'd0, 31'd0));
    pending_req_q.push_back(make_req(kvt_pkg::MODE_GET,      64'd0, 64'd0, 31'd0));
    pending_req_q.push_back(make_req(kvt_pkg::MODE_GET,      '1,    64'd0, 31'd0));
    pending_req_q.push_back(make_req(kvt_pkg::MODE_CONTAINS, '1,    64'd0, 31'd0));
    pending_req_q.push_back(make_req(kvt_pkg::MODE_CONTAINS, key_a, 64'd0, 31'd0));
    pending_req_q.push_back(make_req(kvt_pkg::MODE_REMOVE,   key_a, 64'd0, 31'd0));
    pending_req_q.push_back(make_req(kvt_pkg::MODE_PUT_TTL,  key_a, rand64(), 31'd0));
    pending_req_q.push_back(make_req(kvt_pkg::MODE_GET,      key_a, 64'd0, 31'd0));
    pending_req_q.push_back(make_req(kvt_pkg::MODE_PUT_TTL,  key_b, rand64(), '1));
    pending_req_q.push_back(make_req(kvt_pkg::MODE_PUT_TTL,  key_c, rand64(), 31'd2));
    pending_req_q.push_back(make_req(kvt_pkg::MODE_TICK,     64'd0, 64'd0, 31'd0));
    pending_req_q.push_back(make_req(kvt_pkg::MODE_GET,      key_c, 64'd0, 31'd0));
    pending_req_q.push_back(make_req(kvt_pkg::MODE_TICK,     64'd0, 64'd0, 31'd0));
    pending_req_q.push_back(make_req(kvt_pkg::MODE_GET,      key_c, 64'd0, 31'd0));
    pending_req_q.push_back(make_req(kvt_pkg::MODE_PUT_TTL,  64'd0, rand64(), 31'd1));
    pending_req_q.push_back(make_req(kvt_pkg::MODE_PUT,      key_b, rand64(), 31'd0));
    pending_req_q.push_back(make_req(kvt_pkg::MODE_TICK,     64'd0, 64'd0, 31'd0));
    pending_req_q.push_back(make_req(kvt_pkg::MODE_CONTAINS, 64'd0, 64'd0, 31'd0));
    pending_req_q.push_back(make_req(MODE_SPARE6,            rand64(), rand64(), 31'd5));
    pending_req_q.push_back(make_req(MODE_SPARE7,            '1, '1, '1));
    pending_req_q.push_back(make_req(kvt_pkg::MODE_REMOVE,   '1,    64'd0, 31'd0));
    pending_req_q.push_back(make_req(kvt_pkg::MODE_GET,      key_b, 64'd0, 31'd0));

    // Random part: most keys come from a small pool so that puts replace,
    // gets hit and the table fills; short TTLs with frequent ticks make entries
    // expire. A few requests carry fully random fields.
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL_N; i++) key_pool[i] = rand64();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      key_sel = ($urandom_range(9) == 0) ? rand64() : key_pool[$urandom_range(KEY_POOL_N - 1)];
      pick    = $urandom_range(3);
      data    = (pick == 0) ? '0 : (pick == 1) ? '1 : rand64();
      pick    = $urandom_range(9);
      ttl     = (pick < 7) ? 31'($urandom_range(6)) : (pick < 9) ? 31'($urandom) : '1;
      pick    = $urandom_range(99);
      if (pick < 22)      mode_sel = kvt_pkg::MODE_PUT;
      else if (pick < 42) mode_sel = kvt_pkg::MODE_PUT_TTL;
      else if (pick < 60) mode_sel = kvt_pkg::MODE_GET;
      else if (pick < 70) mode_sel = kvt_pkg::MODE_REMOVE;
      else if (pick < 80) mode_sel = kvt_pkg::MODE_CONTAINS;
      else if (pick < 95) mode_sel = kvt_pkg::MODE_TICK;
      else if (pick < 98) mode_sel = MODE_SPARE6;
      else                mode_sel = MODE_SPARE7;
      if (mode_sel == MODE_SPARE6 || mode_sel == MODE_SPARE7)
        pending_req_q.push_back(make_req(mode_sel, rand64(), rand64(), ttl));
      else
        pending_req_q.push_back(make_req(mode_sel, key_sel, data, ttl));
    end

    item_total = pending_req_q.size();

    // Hold reset low, then release it once.
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every request is taken and every response has come back,
    // then let the block settle so that any stray response still shows up.
    while (req_accepted != item_total) @(posedge clk_i);
    while (rsp_expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("kv_table_with_expiry_unit_test: PASS");
    end else begin
      $display("kv_table_with_expiry_unit_test: FAIL");
    end
    $finish;
  end

endmodule
